// ===== rtl/rcfd_pkg.sv =====
// Package for the remote-control receiver frame decoder.
// Holds the request structs, register indexes and the key/button tracker step.
// No dependencies.
`default_nettype none

package rcfd_pkg;

  localparam int FRAME_LEN = 18;
  localparam int KEY_COUNT = 16;
  localparam int TRACKERS  = 18;
  localparam int POS_W     = 5;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_STICK_CENTER   = 2'd0,
    REG_CHANNEL_LIMIT  = 2'd1,
    REG_MOUSE_LIMIT    = 2'd2,
    REG_UNUSED         = 2'd3
  } cfg_reg_t;

  localparam logic [10:0] CENTER_RESET      = 11'd1024;
  localparam logic [10:0] CHAN_LIMIT_RESET  = 11'd660;
  localparam logic [14:0] MOUSE_LIMIT_RESET = 15'd32767;

  // Tracker codes
  typedef enum logic [1:0] {
    TRK_RELEASED = 2'd0,
    TRK_RISING   = 2'd1,
    TRK_PRESSED  = 2'd2,
    TRK_FALLING  = 2'd3
  } trk_state_t;

  typedef struct packed {
    trk_state_t  status;
    logic [1:0]  count;
  } trk_t;

  typedef struct packed {
    logic [7:0]       frame_byte;
    logic [POS_W-1:0] byte_position;
  } in_req_t;

  typedef struct packed {
    logic signed [11:0] stick0;
    logic signed [11:0] stick1;
    logic signed [11:0] stick2;
    logic signed [11:0] stick3;
    logic signed [11:0] wheel_value;
    logic [1:0]         switch_left;
    logic [1:0]         switch_right;
    logic signed [15:0] mouse_dx;
    logic signed [15:0] mouse_dy;
    logic signed [15:0] mouse_dz;
    logic [31:0]        key_states;
    logic [3:0]         button_states;
  } out_req_t;

  // Raw 11-bit channel minus center; always fits 12 bits signed.
  function automatic logic signed [11:0] centered(input logic [10:0] raw,
                                                  input logic [10:0] center);
    centered = $signed({1'b0, raw}) - $signed({1'b0, center});
  endfunction

  function automatic logic [10:0] chan_mag(input logic signed [11:0] v);
    logic signed [11:0] neg;
    neg = -v;
    chan_mag = v[11] ? neg[10:0] : v[10:0];
  endfunction

  // Magnitude of a 16-bit signed word; -32768 gives 32768.
  function automatic logic [15:0] word_mag(input logic signed [15:0] v);
    logic [15:0] neg;
    neg = 16'(-v);
    word_mag = v[15] ? neg : v;
  endfunction

  // One frame of a press tracker: count saturates at 2 while held.
  function automatic trk_t trk_step(input trk_t cur, input logic pressed);
    trk_t nxt;
    if (!pressed) begin
      nxt.count = 2'd0;
    end else if (cur.count >= 2'd2) begin
      nxt.count = 2'd2;
    end else begin
      nxt.count = cur.count + 2'd1;
    end
    priority if (nxt.count == 2'd2) begin
      nxt.status = TRK_PRESSED;
    end else if (nxt.count == 2'd1) begin
      nxt.status = TRK_RISING;
    end else if (cur.status == TRK_PRESSED) begin
      nxt.status = TRK_FALLING;
    end else begin
      nxt.status = TRK_RELEASED;
    end
    trk_step = nxt;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rc_receiver_frame_decoder.sv =====
// Top level of the remote-control receiver frame decoder.
// Depends on rcfd_pkg for request structs, register indexes and tracker step.
// Usage:
//   in_valid/in_ready/in_data carry one frame byte and its position (0..17).
//   Bytes are kept in an 18-entry frame store; positions above 17 are dropped.
//   The byte at position 17 completes the frame: one result request goes out
//   on out_valid/out_ready/out_data with centered sticks and wheel, switches,
//   mouse x/y/z and the 18 key/button trackers, which advance once per frame.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write stick_center (0),
//   channel_limit (1) and mouse_limit (2); cfg_ready is always high.
// Timing:
//   A request is taken into an input register; from there it is stored
//   and, for position 17, the result is computed in one pass and lands in the
//   output register, which drives out_valid. One byte per cycle is sustained
//   while the output is drained.
// Reset (rst_n low, synchronous): trackers released, config at defaults,
//   pipeline empty. The frame store is not cleared.
// Stall: while out_valid waits on out_ready, bytes other than position 17 keep
//   flowing; a completed frame waits in the input register until the output
//   frees, and in_ready drops behind it.
`default_nettype none

module rc_receiver_frame_decoder
  import rcfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_req_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_req_t         out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_data
);

  // Config registers
  logic [10:0] center_r;
  logic [10:0] chan_limit_r;
  logic [14:0] mouse_limit_r;

  // Input register
  logic    a_valid_r;
  in_req_t a_req_r;

  // Frame store and trackers
  logic [7:0] frame_store_r [FRAME_LEN];
  trk_t       trk_r [TRACKERS];
  trk_t       trk_nxt [TRACKERS];

  // Output register
  logic     out_valid_r;
  out_req_t out_data_r;
  out_req_t out_data_nxt;

  logic out_free;
  logic a_last;
  logic a_adv;
  logic load_out;
  logic in_fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r      <= CENTER_RESET;
      chan_limit_r  <= CHAN_LIMIT_RESET;
      mouse_limit_r <= MOUSE_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STICK_CENTER:   center_r      <= cfg_data[10:0];
        REG_CHANNEL_LIMIT:  chan_limit_r  <= cfg_data[10:0];
        REG_MOUSE_LIMIT:    mouse_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: a completed frame needs a free output slot to advance.
  assign out_free = !out_valid_r || out_ready;
  assign a_last   = (a_req_r.byte_position == LAST_POS);
  assign a_adv    = a_valid_r && (!a_last || out_free);
  assign load_out = a_adv && a_last;
  assign in_ready = !a_valid_r || a_adv;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_req_r <= in_data;
    end
  end

  // Store write; positions above the frame are dropped
  always_ff @(posedge clk) begin
    if (a_adv && (a_req_r.byte_position < POS_W'(FRAME_LEN))) begin
      frame_store_r[a_req_r.byte_position] <= a_req_r.frame_byte;
    end
  end

  // Decode of one completed frame. Byte 17 comes straight from the input
  // register; all other bytes are already in the store.
  always_comb begin
    logic [7:0]         b [FRAME_LEN];
    logic signed [11:0] ch [4];
    logic [10:0]        raw [4];
    logic               over;
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic [15:0]        keys;
    logic [14:0]        dummy_w;
    for (int i = 0; i < FRAME_LEN - 1; i++) begin
      b[i] = frame_store_r[i];
    end
    b[FRAME_LEN-1] = a_req_r.frame_byte;

    raw[0] = {b[1][2:0], b[0]};
    raw[1] = {b[2][5:0], b[1][7:3]};
    raw[2] = {b[4][0], b[3], b[2][7:6]};
    raw[3] = {b[5][3:0], b[4][7:1]};
    over = 1'b0;
    for (int i = 0; i < 4; i++) begin
      ch[i] = centered(raw[i], center_r);
      if (chan_mag(ch[i]) > chan_limit_r) begin
        over = 1'b1;
      end
    end

    out_data_nxt.stick0      = over ? 12'sd0 : ch[0];
    out_data_nxt.stick1      = over ? 12'sd0 : ch[1];
    out_data_nxt.stick2      = over ? 12'sd0 : ch[2];
    out_data_nxt.stick3      = over ? 12'sd0 : ch[3];
    out_data_nxt.wheel_value = centered({b[17][2:0], b[16]}, center_r);
    out_data_nxt.switch_left  = b[5][7:6];
    out_data_nxt.switch_right = b[5][5:4];

    mx = {b[7], b[6]};
    my = {b[9], b[8]};
    dummy_w = mouse_limit_r;
    if ((word_mag(mx) > {1'b0, dummy_w}) || (word_mag(my) > {1'b0, dummy_w})) begin
      mx = 16'sd0;
      my = 16'sd0;
    end
    out_data_nxt.mouse_dx = mx;
    out_data_nxt.mouse_dy = my;
    out_data_nxt.mouse_dz = {b[11], b[10]};

    // Trackers: keys 0..15, then left and right mouse buttons
    keys = {b[15], b[14]};
    for (int i = 0; i < KEY_COUNT; i++) begin
      trk_nxt[i] = trk_step(trk_r[i], keys[i]);
    end
    trk_nxt[KEY_COUNT]     = trk_step(trk_r[KEY_COUNT], b[12][0]);
    trk_nxt[KEY_COUNT + 1] = trk_step(trk_r[KEY_COUNT + 1], b[13][0]);

    for (int i = 0; i < KEY_COUNT; i++) begin
      out_data_nxt.key_states[2*i +: 2] = trk_nxt[i].status;
    end
    out_data_nxt.button_states = {trk_nxt[KEY_COUNT + 1].status,
                                  trk_nxt[KEY_COUNT].status};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TRACKERS; i++) begin
        trk_r[i] <= '{status: TRK_RELEASED, count: 2'd0};
      end
    end else if (load_out) begin
      for (int i = 0; i < TRACKERS; i++) begin
        trk_r[i] <= trk_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= load_out;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // A result appears only when a completed frame advanced the cycle before.
  a_out_from_frame: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(load_out))
    else $error("result without a completed frame");

  // A blocked frame byte stays in the input register unchanged.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !a_adv |=> a_valid_r && $stable(a_req_r))
    else $error("input register lost a blocked request");

  // Tracker status agrees with its count.
  for (genvar g = 0; g < TRACKERS; g++) begin : g_trk_chk
    a_trk_consistent: assert property (@(posedge clk) disable iff (!rst_n)
      (trk_r[g].count != 2'd3) &&
      ((trk_r[g].status == TRK_PRESSED) == (trk_r[g].count == 2'd2)))
      else $error("tracker status and count disagree");
  end
`endif

endmodule

`default_nettype wire
